@@ rtl/core/dad_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dad_pkg;

  localparam int DAYS_WIDTH = 20;
  localparam int DAY_W      = 5;
  localparam int MON_W      = 4;
  localparam int YEAR_W     = 14;
  localparam int Y400_W     = 9;
  localparam int REM_W      = (DAYS_WIDTH > 9) ? DAYS_WIDTH : 9;
  localparam int DATE_W     = DAY_W + MON_W + YEAR_W;
  localparam int S_TDATA_W  = ((DATE_W + DAYS_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((DATE_W + 7) / 8) * 8;

  localparam logic [YEAR_W-1:0] YEAR_MAX   = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0] CYCLE_YRS  = YEAR_W'(400);
  localparam logic [Y400_W-1:0] CYCLE_LAST = Y400_W'(399);
  localparam logic [MON_W-1:0]  MON_JAN    = MON_W'(1);
  localparam logic [MON_W-1:0]  MON_FEB    = MON_W'(2);
  localparam logic [MON_W-1:0]  MON_APR    = MON_W'(4);
  localparam logic [MON_W-1:0]  MON_JUN    = MON_W'(6);
  localparam logic [MON_W-1:0]  MON_SEP    = MON_W'(9);
  localparam logic [MON_W-1:0]  MON_NOV    = MON_W'(11);
  localparam logic [MON_W-1:0]  MON_DEC    = MON_W'(12);
  localparam logic [DAY_W-1:0]  DAY_LEAP   = DAY_W'(29);

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  mon;
    logic [YEAR_W-1:0] year;
    logic [Y400_W-1:0] y400;
    logic [REM_W-1:0]  rem;
  } date_t;

  function automatic logic is_leap(input logic [Y400_W-1:0] y400);
    logic cent;
    cent = (y400 == Y400_W'(100)) || (y400 == Y400_W'(200)) || (y400 == Y400_W'(300));
    return (y400 == '0) || ((y400[1:0] == 2'b00) && !cent);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mon,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (mon == MON_FEB) begin
      len = leap ? DAY_W'(29) : DAY_W'(28);
    end else if ((mon == MON_APR) || (mon == MON_JUN) || (mon == MON_SEP) ||
                 (mon == MON_NOV)) begin
      len = DAY_W'(30);
    end else begin
      len = DAY_W'(31);
    end
    return len;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dad_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dad_step (
  input  var dad_pkg::date_t cur_i,
  output dad_pkg::date_t     nxt_o,
  output logic               fin_o
);

  logic                          leap_cur;
  logic                          leap_nxt;
  logic [dad_pkg::Y400_W-1:0]    y400_inc;
  logic                          feb29;
  logic [8:0]                    ylen;
  logic [dad_pkg::REM_W-1:0]     ylen_ext;
  logic [dad_pkg::DAY_W-1:0]     mlen;
  logic [dad_pkg::DAY_W-1:0]     left;
  logic [dad_pkg::DAY_W:0]       left_inc;
  logic                          take_year;
  logic                          fits;

  assign leap_cur = dad_pkg::is_leap(cur_i.y400);
  assign y400_inc = (cur_i.y400 == dad_pkg::CYCLE_LAST) ? '0 :
                    cur_i.y400 + dad_pkg::Y400_W'(1);
  assign leap_nxt = dad_pkg::is_leap(y400_inc);
  assign feb29    = (cur_i.mon == dad_pkg::MON_FEB) && (cur_i.day == dad_pkg::DAY_LEAP);
  assign ylen     = 9'd365 + {8'd0, (cur_i.mon <= dad_pkg::MON_FEB) ? leap_cur : leap_nxt};
  assign ylen_ext = dad_pkg::REM_W'(ylen);
  assign mlen     = dad_pkg::month_len(cur_i.mon, leap_cur);
  assign left     = mlen - cur_i.day;
  assign left_inc = {1'b0, left} + 6'd1;

  assign take_year = !feb29 && (cur_i.rem >= ylen_ext);
  assign fits      = cur_i.rem <= dad_pkg::REM_W'(left);

  always_comb begin
    nxt_o = cur_i;
    fin_o = 1'b0;
    if (take_year) begin
      nxt_o.year = cur_i.year + dad_pkg::YEAR_W'(1);
      nxt_o.y400 = y400_inc;
      nxt_o.rem  = cur_i.rem - ylen_ext;
    end else if (fits) begin
      nxt_o.day = cur_i.day + cur_i.rem[dad_pkg::DAY_W-1:0];
      nxt_o.rem = '0;
      fin_o     = 1'b1;
    end else begin
      nxt_o.day = dad_pkg::DAY_W'(1);
      nxt_o.rem = cur_i.rem - dad_pkg::REM_W'(left_inc);
      if (cur_i.mon == dad_pkg::MON_DEC) begin
        nxt_o.mon  = dad_pkg::MON_JAN;
        nxt_o.year = cur_i.year + dad_pkg::YEAR_W'(1);
        nxt_o.y400 = y400_inc;
      end else begin
        nxt_o.mon = cur_i.mon + dad_pkg::MON_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/date_add_days.sv @@
// Gregorian date adder: one transfer in gives the date add_days days after the
// start date, one transfer out. A start date that does not exist is echoed
// with bad_date set. An item is first registered; its year is then reduced
// modulo 400 by repeated subtraction of 400, the date is checked, and the
// single step unit steps it on by a whole year or to the next month at a
// time until the remaining days fit in the current month. Input is taken
// only while idle; a finished result waits in the output register while the
// next item is worked on.
`timescale 1ns / 1ps
`default_nettype none

module date_add_days (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // start_day, start_month, start_year, add_days, zero fill
  input  wire  [dad_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  wire                               m_axis_tready_i,
  // end_day, end_month, end_year, zero fill
  output logic [dad_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  // bad_date
  output logic                              m_axis_tuser_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_STEP = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam int DW = dad_pkg::DAY_W;
  localparam int MW = dad_pkg::MON_W;
  localparam int YW = dad_pkg::YEAR_W;

  logic [2:0]                     state_q, state_d;
  dad_pkg::date_t                 cur_q, cur_d;
  logic [YW-1:0]                  red_q, red_d;
  logic                           bad_q, bad_d;
  logic                           m_valid_q, m_valid_d;
  logic [dad_pkg::M_TDATA_W-1:0]  m_data_q, m_data_d;
  logic                           m_user_q, m_user_d;

  dad_pkg::date_t                 nxt;
  logic                           fin;
  logic                           in_fire;
  logic                           chk_leap;
  logic [DW-1:0]                  chk_len;
  logic                           chk_bad;

  dad_step u_step (
    .cur_i (cur_q),
    .nxt_o (nxt),
    .fin_o (fin)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign chk_leap = dad_pkg::is_leap(red_q[dad_pkg::Y400_W-1:0]);
  assign chk_len  = dad_pkg::month_len(cur_q.mon, chk_leap);
  assign chk_bad  = (cur_q.mon < dad_pkg::MON_JAN) || (cur_q.mon > dad_pkg::MON_DEC) ||
                    (cur_q.year < YW'(1)) || (cur_q.year > dad_pkg::YEAR_MAX) ||
                    (cur_q.day < DW'(1)) || (cur_q.day > chk_len);

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    red_d     = red_q;
    bad_d     = bad_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cur_d.day  = s_axis_tdata_i[DW-1:0];
          cur_d.mon  = s_axis_tdata_i[DW+MW-1:DW];
          cur_d.year = s_axis_tdata_i[DW+MW+YW-1:DW+MW];
          cur_d.y400 = '0;
          cur_d.rem  = dad_pkg::REM_W'(
                         s_axis_tdata_i[dad_pkg::DATE_W+dad_pkg::DAYS_WIDTH-1:dad_pkg::DATE_W]);
          red_d      = s_axis_tdata_i[DW+MW+YW-1:DW+MW];
          state_d    = S_RED;
        end
      end
      S_RED: begin
        if (red_q >= dad_pkg::CYCLE_YRS) begin
          red_d = red_q - dad_pkg::CYCLE_YRS;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        cur_d.y400 = red_q[dad_pkg::Y400_W-1:0];
        bad_d      = chk_bad;
        state_d    = (chk_bad || (cur_q.rem == '0)) ? S_DONE : S_STEP;
      end
      S_STEP: begin
        cur_d = nxt;
        if (fin) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = dad_pkg::M_TDATA_W'({cur_q.year, cur_q.mon, cur_q.day});
          m_user_d  = bad_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    red_q    <= red_d;
    bad_q    <= bad_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

`default_nettype wire
